[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the histogram RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHIST_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("chist assertion failed");
`define CHIST_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("chist assertion failed");
`else
`define CHIST_ASSERT(label, clk, rstn, prop)
`define CHIST_ASSERT_NR(label, clk, prop)
`endif
`endif

[design/chist_pkg.sv]
// ----------------------------------------------------------------------------
// chist_pkg
// Types, constants and helpers for the clamped image histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chist_pkg;

    localparam int NUM_BINS    = 256;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_AW      = $clog2(NUM_BINS);
    localparam int SAMPLE_W    = 16;
    localparam int INDEX_W     = 8;
    localparam int OUT_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] CMD_COUNT = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 1'd1;

    localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 16'sd255;

    typedef logic [BIN_AW-1:0]      bin_addr_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic [1:0]                 command;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         bin_index;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] bin_count;
        logic             index_error;
    } out_item_t;

    typedef struct packed {
        bin_addr_t count_addr;
        bin_addr_t read_addr;
        logic      read_err;
    } bin_sel_t;

    function automatic logic [OUT_W-1:0] sat_out(count_t c);
        logic [63:0] w;
        w = 64'(c);
        if (w > 64'h0000_0000_FFFF_FFFF) begin
            return '1;
        end
        return w[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/clamped_image_histogram.sv]
// ----------------------------------------------------------------------------
// clamped_image_histogram
// Histogram of signed samples with clamping, saturating bin counters in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_item carries a command: count a sample, read a bin, or clear all bins.
//   Only a read gives an item on m_item: the bin count and an error flag for
//   an index outside the configured span (count then reads as zero).
//   cfg_we/cfg_index/cfg_wdata set min_value and max_value; write them only
//   while the block is idle.
//   Throughput: one item per cycle while s_ready is high. Each item runs
//   two stages: the bin RAM is read in the accept cycle, and the incremented
//   count is written back in the next; a forwarding register covers a count to
//   the same bin that follows directly. A read result passes the second stage
//   and the output register before it appears on m_valid.
//   Clear drops a valid bit per bin, and unwritten bins read as zero. Reset
//   clears those bits at once, no RAM pass is needed.
//   When m_ready is low while a result is already held, a read waits in the
//   second stage and s_ready falls, so counts and clears wait as well.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clamped_image_histogram import chist_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic signed [SAMPLE_W-1:0] min_value_reg;
    logic signed [SAMPLE_W-1:0] max_value_reg;

    logic [NUM_BINS-1:0] valid_bits_reg;

    logic       s1_valid_reg;
    logic [1:0] s1_cmd_reg;
    bin_addr_t  s1_addr_reg;
    logic       s1_err_reg;
    logic       rvalid_reg;

    logic       fwd_valid_reg;
    bin_addr_t  fwd_addr_reg;
    count_t     fwd_data_reg;

    logic       m_valid_reg;
    out_item_t  m_item_reg;

    bin_sel_t   sel;
    bin_addr_t  rd_addr;
    count_t     rd_data;
    count_t     cur;
    count_t     inc;
    logic       out_free;
    logic       advance;
    logic       s1_read;
    logic       s1_count;
    logic       s1_clear;
    logic       fwd_hit;

    chist_index u_index (
        .min_value (min_value_reg),
        .max_value (max_value_reg),
        .sample    (s_item.sample),
        .bin_index (s_item.bin_index),
        .sel       (sel)
    );

    assign rd_addr = (s_item.command == CMD_COUNT) ? sel.count_addr : sel.read_addr;

    chist_ram #(
        .DEPTH (NUM_BINS),
        .WIDTH (COUNT_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (advance),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (s1_count),
        .wr_addr (s1_addr_reg),
        .wr_data (inc)
    );

    assign s1_read  = s1_valid_reg && (s1_cmd_reg == CMD_READ);
    assign s1_count = s1_valid_reg && (s1_cmd_reg == CMD_COUNT);
    assign s1_clear = s1_valid_reg && (s1_cmd_reg == CMD_CLEAR);
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = !(s1_read && !out_free);
    assign s_ready  = advance;

    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == s1_addr_reg);

    always_comb begin
        if (fwd_hit) begin
            cur = fwd_data_reg;
        end else if (rvalid_reg) begin
            cur = rd_data;
        end else begin
            cur = '0;
        end
        inc = (cur == '1) ? cur : cur + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_value_reg  <= MIN_RESET;
            max_value_reg  <= MAX_RESET;
            valid_bits_reg <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MIN_VALUE: min_value_reg <= cfg_wdata;
                    CFG_MAX_VALUE: max_value_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (s1_count) begin
                valid_bits_reg[s1_addr_reg] <= 1'b1;
                fwd_valid_reg               <= 1'b1;
            end else if (s1_clear) begin
                valid_bits_reg <= '0;
                fwd_valid_reg  <= 1'b0;
            end

            if (advance) begin
                s1_valid_reg <= s_valid;
            end

            if (out_free) begin
                m_valid_reg <= s1_read;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_cmd_reg  <= s_item.command;
            s1_addr_reg <= rd_addr;
            s1_err_reg  <= sel.read_err;
            rvalid_reg  <= valid_bits_reg[rd_addr] && !s1_clear;
        end
        if (s1_count) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= inc;
        end
        if (out_free && s1_read) begin
            m_item_reg.bin_count   <= s1_err_reg ? '0 : sat_out(cur);
            m_item_reg.index_error <= s1_err_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `CHIST_ASSERT(a_clear_drops_bins, aclk, aresetn, s1_clear |=> (valid_bits_reg == '0))
    `CHIST_ASSERT(a_count_arms_fwd, aclk, aresetn, s1_count |=> fwd_valid_reg)
    `CHIST_ASSERT(a_read_delivers, aclk, aresetn, (s1_read && out_free) |=> m_valid_reg)
    `CHIST_ASSERT(a_err_zero_count, aclk, aresetn, (m_valid_reg && m_item.index_error) |-> (m_item.bin_count == '0))

endmodule

`default_nettype wire

[design/chist_ram.sv]
// ----------------------------------------------------------------------------
// chist_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chist_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/chist_index.sv]
// ----------------------------------------------------------------------------
// chist_index
// Clamps a sample into a bin address and range-checks a read index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chist_index import chist_pkg::*; (
    input  wire logic signed [SAMPLE_W-1:0] min_value,
    input  wire logic signed [SAMPLE_W-1:0] max_value,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic        [INDEX_W-1:0]  bin_index,
    output bin_sel_t                        sel
);

    logic signed [SAMPLE_W-1:0] clamped;
    logic signed [SAMPLE_W:0]   offset;
    logic signed [17:0]         diff;
    logic signed [17:0]         span;

    always_comb begin
        if (sample < min_value) begin
            clamped = min_value;
        end else if (sample > max_value) begin
            clamped = max_value;
        end else begin
            clamped = sample;
        end

        offset = 17'(clamped) - 17'(min_value);
        if (offset < 0) begin
            sel.count_addr = '0;
        end else if (offset > 17'(NUM_BINS - 1)) begin
            sel.count_addr = BIN_AW'(NUM_BINS - 1);
        end else begin
            sel.count_addr = BIN_AW'(offset);
        end

        diff = 18'(max_value) - 18'(min_value) + 18'sd1;
        if (diff < 18'sd1) begin
            span = 18'sd1;
        end else if (diff > 18'(NUM_BINS)) begin
            span = 18'(NUM_BINS);
        end else begin
            span = diff;
        end

        sel.read_err  = (18'(bin_index) >= 18'(span));
        sel.read_addr = BIN_AW'(bin_index);
    end

endmodule

`default_nettype wire

[dv/tb_clamped_image_histogram.sv]
// ----------------------------------------------------------------------------
// tb_clamped_image_histogram
// Self-checking bench for the clamped image histogram. A directed table walks
// the bin extremes, every command, narrow, inverted and full-range limits and
// out-of-span reads. Random phases then exercise count/read/clear traffic under
// a range of limit settings. Each read result is checked against the table's
// expected value or a local model of the bin store, with random idle cycles on
// both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_clamped_image_histogram;
    import chist_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic       ROW_ITEM     = 1'b0;
    localparam logic       ROW_WRITE    = 1'b1;
    localparam int         PHASES       = 10;
    localparam int         PHASE_ITEMS  = 128;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         STALL_LIMIT  = 2000;

    typedef struct packed {
        logic        kind;
        logic [1:0]  op;
        logic [15:0] value;
        logic [7:0]  index;
        logic        typed;
        logic [31:0] want_count;
        logic        want_err;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    count_t    hist_bins [NUM_BINS];
    int        lo_limit;
    int        hi_limit;
    out_item_t expected_reads [$];
    out_item_t want;
    row_t      directed_rows [$];

    int  mismatches;
    int  items_sent;
    int  reads_checked;
    int  clears_sent;
    int  settings_used;
    int  stall_cycles;
    bit  steady;
    bit  hold_output;

    clamped_image_histogram uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 40) begin
            $display("mismatch at %0t: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic int span_now();
        int span;
        span = hi_limit - lo_limit + 1;
        if (span < 1) span = 1;
        if (span > NUM_BINS) span = NUM_BINS;
        return span;
    endfunction

    function automatic bit histogram_step(input in_item_t it, output out_item_t rd);
        int          v;
        int          off;
        logic [63:0] c;
        rd = '0;
        case (it.command)
            CMD_COUNT: begin
                v = int'($signed(it.sample));
                if (v < lo_limit) v = lo_limit;
                else if (v > hi_limit) v = hi_limit;
                off = v - lo_limit;
                if (off < 0) off = 0;
                if (off > NUM_BINS - 1) off = NUM_BINS - 1;
                if (hist_bins[off[BIN_AW-1:0]] != '1) begin
                    hist_bins[off[BIN_AW-1:0]] = hist_bins[off[BIN_AW-1:0]] + 1'b1;
                end
            end
            CMD_READ: begin
                if (int'(it.bin_index) >= span_now()) begin
                    rd.bin_count   = '0;
                    rd.index_error = 1'b1;
                end else begin
                    c = 64'(hist_bins[it.bin_index]);
                    rd.bin_count = (c > 64'h0000_0000_FFFF_FFFF) ? '1 : c[OUT_W-1:0];
                end
            end
            CMD_CLEAR: begin
                foreach (hist_bins[i]) hist_bins[i] = '0;
            end
            default: ;
        endcase
        return it.command == CMD_READ;
    endfunction

    task automatic issue_item(input in_item_t it, input bit typed, input out_item_t typed_res);
        out_item_t rd;
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (it.command == CMD_CLEAR) clears_sent++;
        if (histogram_step(it, rd)) expected_reads.push_back(typed ? typed_res : rd);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_reads.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_VALUE) lo_limit = int'($signed(val));
        else hi_limit = int'($signed(val));
    endtask

    task automatic set_limits(input int lo, input int hi);
        write_reg(CFG_MIN_VALUE, lo[15:0]);
        write_reg(CFG_MAX_VALUE, hi[15:0]);
        settings_used++;
    endtask

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        int       s;
        int       span;
        it.sample    = 16'($urandom);
        it.bin_index = 8'($urandom);
        pick = $urandom_range(0, 99);
        span = span_now();
        if (pick < 55) begin
            it.command = CMD_COUNT;
            if ($urandom_range(0, 9) < 7) begin
                if (hi_limit >= lo_limit) begin
                    s = lo_limit - 3 + $urandom_range(0, hi_limit - lo_limit + 6);
                end else begin
                    s = ($urandom_range(0, 1) ? lo_limit : hi_limit) + $urandom_range(0, 8) - 4;
                end
                it.sample = s[15:0];
            end
        end else if (pick < 92) begin
            it.command = CMD_READ;
            if ($urandom_range(0, 9) < 7) begin
                it.bin_index = 8'($urandom_range(0, (span < 255) ? span : 255));
            end
        end else if (pick < 95) begin
            it.command = CMD_CLEAR;
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_reads.size() == 0) begin
                report_mismatch("read result with no read outstanding");
            end else begin
                want = expected_reads.pop_front();
                if (m_item.bin_count !== want.bin_count) begin
                    report_mismatch($sformatf("bin_count %0d, want %0d",
                                              m_item.bin_count, want.bin_count));
                end
                if (m_item.index_error !== want.index_error) begin
                    report_mismatch($sformatf("index_error %0b, want %0b",
                                              m_item.index_error, want.index_error));
                end
                reads_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_output) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_output = 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 24);
            end
        end
    end

    initial begin
        in_item_t it;
        row_t     row;
        int       lo;
        int       hi;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        stall_cycles = 0;
        steady       = 1'b0;
        hold_output  = 1'b0;
        lo_limit     = int'($signed(MIN_RESET));
        hi_limit     = int'($signed(MAX_RESET));
        foreach (hist_bins[i]) hist_bins[i] = '0;

        directed_rows = '{
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd0,   1'b1, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd255, 1'b1, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_COUNT,  16'sh8000,   8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_COUNT,  16'sh7FFF,   8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_COUNT,  16'sd0,      8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_COUNT,  16'sd17,     8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_COUNT,  16'sd17,     8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_UNUSED, 16'sd17,     8'd17,  1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd0,   1'b1, 32'd2, 1'b0},
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd255, 1'b1, 32'd1, 1'b0},
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd17,  1'b1, 32'd2, 1'b0},
            '{ROW_ITEM,  CMD_CLEAR,  16'sd0,      8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd17,  1'b1, 32'd0, 1'b0},
            '{ROW_WRITE, CFG_MIN_VALUE, -16'sd100, 8'd0,  1'b0, 32'd0, 1'b0},
            '{ROW_WRITE, CFG_MAX_VALUE, -16'sd91,  8'd0,  1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_COUNT,  16'sh8000,   8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_COUNT,  16'sd5,      8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd10,  1'b1, 32'd0, 1'b1},
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd9,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_WRITE, CFG_MIN_VALUE, 16'sh8000, 8'd0,  1'b0, 32'd0, 1'b0},
            '{ROW_WRITE, CFG_MAX_VALUE, 16'sh7FFF, 8'd0,  1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_COUNT,  16'sh7FFF,   8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_COUNT,  -16'sd32767, 8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd255, 1'b0, 32'd0, 1'b0},
            '{ROW_WRITE, CFG_MIN_VALUE, 16'sd100,  8'd0,  1'b0, 32'd0, 1'b0},
            '{ROW_WRITE, CFG_MAX_VALUE, -16'sd100, 8'd0,  1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_COUNT,  16'sd200,    8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_COUNT,  -16'sd200,   8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd0,   1'b0, 32'd0, 1'b0},
            '{ROW_ITEM,  CMD_READ,   16'sd0,      8'd1,   1'b1, 32'd0, 1'b1}
        };

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.op[CFG_IDX_W-1:0], row.value);
            end else begin
                it.command   = row.op;
                it.sample    = row.value;
                it.bin_index = row.index;
                issue_item(it, row.typed, {row.want_count, row.want_err});
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin lo = 0;      hi = 255;   end
                1: begin lo = -32768; hi = 32767; end
                2: begin lo = -50;    hi = 50;    end
                3: begin lo = 32767;  hi = -32768; end
                4: begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    hi = lo;
                end
                5: begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    hi = lo + int'($urandom_range(1, 300));
                    if (hi > 32767) hi = 32767;
                end
                6: begin lo = 32767;  hi = 32767;  end
                7: begin lo = -32768; hi = -32513; end
                8: begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    hi = int'($urandom_range(0, 65535)) - 32768;
                end
                default: begin lo = -1; hi = 254; end
            endcase
            set_limits(lo, hi);
            steady = (p == 4) || (p == 5);
            if (p == 2) hold_output = 1'b1;
            repeat (PHASE_ITEMS) issue_item(random_item(), 1'b0, '0);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_reads.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("run: %0d items issued, %0d reads checked, %0d clears", items_sent,
                 reads_checked, clears_sent);
        $display("run: %0d limit settings plus the directed table, one long output stall",
                 settings_used);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/chist_pkg.sv
design/chist_ram.sv
design/chist_index.sv
design/clamped_image_histogram.sv
dv/tb_clamped_image_histogram.sv
